// File: hw/rtl/mstc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mstc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int WEIGHT_BITS  = 16;

    localparam int VID_BITS   = 6;
    localparam int CFG_BITS   = 7;
    localparam int NV_BITS    = $clog2(MAX_VERTICES + 1);
    localparam int VA_BITS    = $clog2(MAX_VERTICES);
    localparam int EA_BITS    = $clog2(MAX_EDGES);
    localparam int CNT_BITS   = $clog2(MAX_EDGES + 1);
    localparam int RANK_BITS  = 3;
    localparam int RANK_MAX   = 7;
    localparam int COST_BITS  = 24;
    localparam int COUNT_BITS = 6;
    localparam int ACC_BITS   = WEIGHT_BITS + NV_BITS + 2;

    localparam logic signed [ACC_BITS-1:0] COST_HI = ACC_BITS'((2 ** (COST_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS-1:0] COST_LO = ACC_BITS'(-(2 ** (COST_BITS - 1)));
    localparam logic [NV_BITS-1:0] COUNT_MAX = NV_BITS'((2 ** COUNT_BITS) - 1);

    typedef struct packed {
        logic [VID_BITS-1:0]           a;
        logic [VID_BITS-1:0]           b;
        logic signed [WEIGHT_BITS-1:0] w;
    } edge_t;

    typedef struct packed {
        logic [RANK_BITS-1:0] rank;
        logic [VID_BITS-1:0]  parent;
    } uf_word_t;

    typedef struct packed {
        logic                start;
        logic                clr;
        logic [VID_BITS-1:0] a;
        logic [VID_BITS-1:0] b;
    } uf_req_t;

    typedef struct packed {
        logic done;
        logic joined;
    } uf_rsp_t;

endpackage
`default_nettype wire

// File: hw/rtl/min_spanning_tree_cost_core.sv
// Edges load at one beat per cycle; a beat with last_edge set starts the computation.
// After the last beat the edge store is insertion sorted on its single memory, one
// read and one write per cycle, then each edge is read, checked for range and, if
// in range, handed to the union-find walk, which joins the two trees when apart.
// Input stalls until the result beat is registered; one result per graph.
// Reset (rst_n, asynchronous, active low) empties the graph and sets vertex_count to 64.
`timescale 1ns / 1ps
`default_nettype none
module min_spanning_tree_cost_core
    import mstc_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_BITS-1:0]           cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [VID_BITS-1:0]           src_vertex,
    input  wire logic [VID_BITS-1:0]           dst_vertex,
    input  wire logic signed [WEIGHT_BITS-1:0] edge_weight,
    input  wire logic                          last_edge,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COST_BITS-1:0]        total_cost,
    output logic [COUNT_BITS-1:0]              tree_edge_count
);

    typedef enum logic [5:0] {
        T_IDLE = 6'b000001,
        T_SORT = 6'b000010,
        T_RD   = 6'b000100,
        T_CHK  = 6'b001000,
        T_UF   = 6'b010000,
        T_OUT  = 6'b100000
    } top_state_t;

    top_state_t                 st_reg, st_next;
    logic [CFG_BITS-1:0]        vcount_reg;
    logic [CNT_BITS-1:0]        k_reg, k_next;
    logic signed [ACC_BITS-1:0] acc_reg, acc_next;
    logic [NV_BITS-1:0]         taken_reg, taken_next;
    logic signed [WEIGHT_BITS-1:0] w_reg, w_next;
    logic                       ov_reg, ov_next;
    logic signed [COST_BITS-1:0] cost_reg, cost_next;
    logic [COUNT_BITS-1:0]      tcnt_reg, tcnt_next;

    logic [NV_BITS-1:0]         nv;
    logic                       accept;
    logic                       in_range;
    logic                       clr;
    logic                       sort_start;
    logic                       sort_done;
    logic [CNT_BITS-1:0]        count;
    edge_t                      wr_edge;
    edge_t                      rd_data;
    uf_req_t                    uf_req;
    uf_rsp_t                    uf_rsp;

    // A zero vertex count acts as one, anything above the capacity as the capacity.
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            nv = NV_BITS'(1);
        end
        else if (32'(vcount_reg) > 32'(MAX_VERTICES))
        begin
            nv = NV_BITS'(MAX_VERTICES);
        end
        else
        begin
            nv = NV_BITS'(vcount_reg);
        end
    end

    assign in_ready = (st_reg == T_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_range = (NV_BITS'(src_vertex) < nv) && (NV_BITS'(dst_vertex) < nv);

    assign wr_edge.a = src_vertex;
    assign wr_edge.b = dst_vertex;
    assign wr_edge.w = edge_weight;

    always_comb
    begin
        st_next    = st_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        taken_next = taken_reg;
        w_next     = w_reg;
        ov_next    = ov_reg;
        cost_next  = cost_reg;
        tcnt_next  = tcnt_reg;
        clr        = 1'b0;
        sort_start = 1'b0;
        uf_req.start = 1'b0;
        uf_req.a     = rd_data.a;
        uf_req.b     = rd_data.b;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (st_reg)
            T_IDLE:
            begin
                if (accept && last_edge)
                begin
                    sort_start = 1'b1;
                    st_next    = T_SORT;
                end
            end
            T_SORT:
            begin
                if (sort_done)
                begin
                    k_next  = '0;
                    st_next = T_RD;
                end
            end
            T_RD:
            begin
                // The walk ends at the last stored edge or once the tree is complete.
                if ((k_reg >= count) || (taken_reg >= (nv - NV_BITS'(1))))
                begin
                    st_next = T_OUT;
                end
                else
                begin
                    st_next = T_CHK;
                end
            end
            T_CHK:
            begin
                k_next = k_reg + CNT_BITS'(1);
                w_next = rd_data.w;
                if ((NV_BITS'(rd_data.a) >= nv) || (NV_BITS'(rd_data.b) >= nv))
                begin
                    st_next = T_RD;
                end
                else
                begin
                    uf_req.start = 1'b1;
                    st_next      = T_UF;
                end
            end
            T_UF:
            begin
                if (uf_rsp.done)
                begin
                    if (uf_rsp.joined)
                    begin
                        acc_next   = acc_reg + ACC_BITS'(w_reg);
                        taken_next = taken_reg + NV_BITS'(1);
                    end
                    st_next = T_RD;
                end
            end
            T_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    if (acc_reg > COST_HI)
                    begin
                        cost_next = COST_HI[COST_BITS-1:0];
                    end
                    else if (acc_reg < COST_LO)
                    begin
                        cost_next = COST_LO[COST_BITS-1:0];
                    end
                    else
                    begin
                        cost_next = acc_reg[COST_BITS-1:0];
                    end
                    if (taken_reg > COUNT_MAX)
                    begin
                        tcnt_next = COUNT_MAX[COUNT_BITS-1:0];
                    end
                    else
                    begin
                        tcnt_next = taken_reg[COUNT_BITS-1:0];
                    end
                    // Empty the graph for the next one.
                    clr        = 1'b1;
                    acc_next   = '0;
                    taken_next = '0;
                    st_next    = T_IDLE;
                end
            end
            default:
            begin
                st_next = T_IDLE;
            end
        endcase
        uf_req.clr = clr;
    end

    mstc_edge_store u_edges (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (accept && in_range),
        .wr_edge    (wr_edge),
        .clr        (clr),
        .sort_start (sort_start),
        .rd_addr    (k_reg[EA_BITS-1:0]),
        .sort_done  (sort_done),
        .count      (count),
        .rd_data    (rd_data)
    );

    mstc_union_find u_uf (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (uf_req),
        .rsp   (uf_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= T_IDLE;
            vcount_reg <= CFG_BITS'(MAX_VERTICES);
            acc_reg    <= '0;
            taken_reg  <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            acc_reg   <= acc_next;
            taken_reg <= taken_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        w_reg    <= w_next;
        cost_reg <= cost_next;
        tcnt_reg <= tcnt_next;
    end

    assign out_valid       = ov_reg;
    assign total_cost      = cost_reg;
    assign tree_edge_count = tcnt_reg;

endmodule
`default_nettype wire

// File: hw/rtl/mstc_edge_store.sv
`timescale 1ns / 1ps
`default_nettype none
module mstc_edge_store
    import mstc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire edge_t               wr_edge,
    input  wire logic                clr,
    input  wire logic                sort_start,
    input  wire logic [EA_BITS-1:0]  rd_addr,
    output logic                     sort_done,
    output logic [CNT_BITS-1:0]      count,
    output edge_t                    rd_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_NEXT  = 5'b00010,
        S_LOADT = 5'b00100,
        S_SHIFT = 5'b01000,
        S_PLACE = 5'b10000
    } sort_state_t;

    edge_t mem [MAX_EDGES];

    sort_state_t         st_reg, st_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [CNT_BITS-1:0] i_reg, i_next;
    logic [EA_BITS-1:0]  j_reg, j_next;
    edge_t               t_reg, t_next;
    edge_t               rdata_reg;

    logic [EA_BITS-1:0]  raddr;
    logic                we;
    logic [EA_BITS-1:0]  waddr;
    edge_t               wdata;

    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        t_next    = t_reg;
        raddr     = rd_addr;
        we        = 1'b0;
        waddr     = cnt_reg[EA_BITS-1:0];
        wdata     = wr_edge;
        sort_done = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (wr_en && (cnt_reg < CNT_BITS'(MAX_EDGES)))
                begin
                    we       = 1'b1;
                    cnt_next = cnt_reg + CNT_BITS'(1);
                end
                if (sort_start)
                begin
                    i_next  = CNT_BITS'(1);
                    st_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (i_reg >= cnt_reg)
                begin
                    sort_done = 1'b1;
                    st_next   = S_IDLE;
                end
                else
                begin
                    raddr     = i_reg[EA_BITS-1:0];
                    st_next   = S_LOADT;
                end
            end
            S_LOADT:
            begin
                t_next  = rdata_reg;
                j_next  = i_reg[EA_BITS-1:0];
                raddr   = i_reg[EA_BITS-1:0] - EA_BITS'(1);
                st_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                we    = 1'b1;
                waddr = j_reg;
                if (rdata_reg.w > t_reg.w)
                begin
                    // Move the larger entry up one slot and keep scanning down.
                    wdata  = rdata_reg;
                    j_next = j_reg - EA_BITS'(1);
                    if (j_reg == EA_BITS'(1))
                    begin
                        st_next = S_PLACE;
                    end
                    else
                    begin
                        raddr = j_reg - EA_BITS'(2);
                    end
                end
                else
                begin
                    wdata   = t_reg;
                    i_next  = i_reg + CNT_BITS'(1);
                    st_next = S_NEXT;
                end
            end
            S_PLACE:
            begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = t_reg;
                i_next  = i_reg + CNT_BITS'(1);
                st_next = S_NEXT;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
        if (clr)
        begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        j_reg <= j_next;
        t_reg <= t_next;
    end

    assign count   = cnt_reg;
    assign rd_data = rdata_reg;

endmodule
`default_nettype wire

// File: hw/rtl/mstc_union_find.sv
`timescale 1ns / 1ps
`default_nettype none
module mstc_union_find
    import mstc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire uf_req_t req,
    output uf_rsp_t      rsp
);

    typedef enum logic [6:0] {
        U_IDLE  = 7'b0000001,
        U_FREAD = 7'b0000010,
        U_FCHK  = 7'b0000100,
        U_CCHK  = 7'b0001000,
        U_FEND  = 7'b0010000,
        U_JOIN  = 7'b0100000,
        U_JOIN2 = 7'b1000000
    } uf_state_t;

    uf_word_t mem [MAX_VERTICES];

    uf_state_t               st_reg, st_next;
    logic [MAX_VERTICES-1:0] valid_reg;
    logic [VID_BITS-1:0]     b_reg, b_next;
    logic [VID_BITS-1:0]     r_reg, r_next;
    logic [VID_BITS-1:0]     x_reg, x_next;
    logic                    phase_reg, phase_next;
    logic [VID_BITS-1:0]     ra_reg, ra_next;
    logic [VID_BITS-1:0]     rb_reg, rb_next;
    logic [RANK_BITS-1:0]    rk_reg, rk_next;
    logic [RANK_BITS-1:0]    rka_reg, rka_next;
    logic [RANK_BITS-1:0]    rkb_reg, rkb_next;

    logic [VID_BITS-1:0]     raddr;
    logic [VID_BITS-1:0]     raddr_q;
    logic                    vld_q;
    uf_word_t                rdata_q;
    uf_word_t                word;
    logic                    we;
    logic [VID_BITS-1:0]     waddr;
    uf_word_t                wdata;

    // An entry never written since the last clear is its own root with rank zero.
    always_comb
    begin
        if (vld_q)
        begin
            word = rdata_q;
        end
        else
        begin
            word.rank   = '0;
            word.parent = raddr_q;
        end
    end

    always_comb
    begin
        st_next    = st_reg;
        b_next     = b_reg;
        r_next     = r_reg;
        x_next     = x_reg;
        phase_next = phase_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        rk_next    = rk_reg;
        rka_next   = rka_reg;
        rkb_next   = rkb_reg;
        raddr      = r_reg;
        we         = 1'b0;
        waddr      = x_reg;
        wdata      = '0;
        rsp.done   = 1'b0;
        rsp.joined = 1'b0;
        unique case (st_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    b_next     = req.b;
                    r_next     = req.a;
                    x_next     = req.a;
                    phase_next = 1'b0;
                    st_next    = U_FREAD;
                end
            end
            U_FREAD:
            begin
                raddr   = r_reg;
                st_next = U_FCHK;
            end
            U_FCHK:
            begin
                if (word.parent == r_reg)
                begin
                    rk_next = word.rank;
                    if (x_reg == r_reg)
                    begin
                        st_next = U_FEND;
                    end
                    else
                    begin
                        raddr   = x_reg;
                        st_next = U_CCHK;
                    end
                end
                else
                begin
                    r_next = word.parent;
                    raddr  = word.parent;
                end
            end
            U_CCHK:
            begin
                // Path compression: point this node straight at the root.
                we           = 1'b1;
                waddr        = x_reg;
                wdata.rank   = word.rank;
                wdata.parent = r_reg;
                x_next       = word.parent;
                if (word.parent == r_reg)
                begin
                    st_next = U_FEND;
                end
                else
                begin
                    raddr = word.parent;
                end
            end
            U_FEND:
            begin
                if (!phase_reg)
                begin
                    ra_next    = r_reg;
                    rka_next   = rk_reg;
                    phase_next = 1'b1;
                    r_next     = b_reg;
                    x_next     = b_reg;
                    st_next    = U_FREAD;
                end
                else
                begin
                    rb_next  = r_reg;
                    rkb_next = rk_reg;
                    if (ra_reg == r_reg)
                    begin
                        rsp.done = 1'b1;
                        st_next  = U_IDLE;
                    end
                    else
                    begin
                        st_next = U_JOIN;
                    end
                end
            end
            U_JOIN:
            begin
                we = 1'b1;
                if (rka_reg < rkb_reg)
                begin
                    waddr        = ra_reg;
                    wdata.rank   = rka_reg;
                    wdata.parent = rb_reg;
                    rsp.done     = 1'b1;
                    rsp.joined   = 1'b1;
                    st_next      = U_IDLE;
                end
                else
                begin
                    waddr        = rb_reg;
                    wdata.rank   = rkb_reg;
                    wdata.parent = ra_reg;
                    if (rka_reg > rkb_reg)
                    begin
                        rsp.done   = 1'b1;
                        rsp.joined = 1'b1;
                        st_next    = U_IDLE;
                    end
                    else
                    begin
                        st_next = U_JOIN2;
                    end
                end
            end
            U_JOIN2:
            begin
                we           = 1'b1;
                waddr        = ra_reg;
                wdata.parent = ra_reg;
                if (rka_reg == RANK_BITS'(RANK_MAX))
                begin
                    wdata.rank = rka_reg;
                end
                else
                begin
                    wdata.rank = rka_reg + RANK_BITS'(1);
                end
                rsp.done   = 1'b1;
                rsp.joined = 1'b1;
                st_next    = U_IDLE;
            end
            default:
            begin
                st_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr[VA_BITS-1:0]] <= wdata;
        end
        rdata_q <= mem[raddr[VA_BITS-1:0]];
        raddr_q <= raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= U_IDLE;
            valid_reg <= '0;
            vld_q     <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            vld_q  <= valid_reg[raddr[VA_BITS-1:0]];
            if (req.clr)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[waddr[VA_BITS-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg     <= b_next;
        r_reg     <= r_next;
        x_reg     <= x_next;
        phase_reg <= phase_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        rk_reg    <= rk_next;
        rka_reg   <= rka_next;
        rkb_reg   <= rkb_next;
    end

endmodule
`default_nettype wire
